// ----- design/sls_pkg.sv -----
// Shared types and constants for the shifting list store.
package sls_pkg;

	// Field widths fixed by the channel payloads
	localparam int CNT_W = 5;
	localparam int OP_W  = 3;
	localparam int ST_W  = 2;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
	localparam logic [OP_W-1:0] OP_EDIT   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

	// Capacity after reset
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	// Memory port strobes from the sequencer
	typedef struct packed {
		logic we;
		logic re;
	} mem_cmd_t;

endpackage

// ----- design/sls_in_if.sv -----
// Input channel: one list operation per transaction.
interface sls_in_if import sls_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [POS_W-1:0] position;
	logic signed [VAL_W-1:0] value_in;

	modport source (output valid, output operation, output position, output value_in,
		input ready);
	modport sink (input valid, input operation, input position, input value_in,
		output ready);
endinterface

// ----- design/sls_out_if.sv -----
// Output channel: one result per transaction.
interface sls_out_if import sls_pkg::*;;
	logic             valid;
	logic             ready;
	logic signed [VAL_W-1:0] read_value;
	logic [ST_W-1:0]  status;
	logic [CNT_W-1:0] fill_count;
	logic             is_full;
	logic             is_empty;

	modport source (output valid, output read_value, output status, output fill_count,
		output is_full, output is_empty, input ready);
	modport sink (input valid, input read_value, input status, input fill_count,
		input is_full, input is_empty, output ready);
endinterface

// ----- design/sls_mem.sv -----
// Entry storage: one write port and one registered read port.
module sls_mem import sls_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32,
	parameter int AW        = 4
) (
	input  logic                 clk,
	input  mem_cmd_t             cmd,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry; hold the data until the next read
	always_ff @(posedge clk) begin
		if (cmd.re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/sls_ctrl.sv -----
// Sequencer: checks each operation and moves entries one at a time through the memory.
module sls_ctrl import sls_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int AW        = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CNT_W-1:0]     cap_eff,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      in_op,
	input  logic [POS_W-1:0]     in_pos,
	input  logic [WORD_BITS-1:0] in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [VAL_W-1:0]     out_read_value,
	output logic [ST_W-1:0]      out_status,
	output logic [CNT_W-1:0]     out_fill_count,
	output logic                 out_is_full,
	output logic                 out_is_empty,
	output mem_cmd_t             mem_cmd,
	output logic [AW-1:0]        mem_waddr,
	output logic [WORD_BITS-1:0] mem_wdata,
	output logic [AW-1:0]        mem_raddr,
	input  logic [WORD_BITS-1:0] mem_rdata,
	input  logic [VAL_W-1:0]     rd_ext
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SH_RD = 3'd1;
	localparam logic [2:0] S_SH_WR = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]           state_q;
	logic [OP_W-1:0]      op_q;
	logic [CNT_W-1:0]     pos_q;
	logic [WORD_BITS-1:0] word_q;
	logic [ST_W-1:0]      status_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     stop_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     src;
	logic [CNT_W-1:0]     pos_in;
	logic                 load_out;

	logic                 out_valid_q;
	logic [VAL_W-1:0]     read_value_q;
	logic [ST_W-1:0]      status_out_q;
	logic [CNT_W-1:0]     fill_q;
	logic                 full_q;
	logic                 empty_q;

	assign pos_in = CNT_W'(in_pos);

	// Step the entry index: down for insert, up for delete
	assign src = (op_q == OP_INSERT) ? idx_q - CNT_W'(1) : idx_q + CNT_W'(1);

	assign in_ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Drive the memory port
	always_comb begin
		mem_cmd.re = (state_q == S_SH_RD) || (state_q == S_READ);
		mem_cmd.we = (state_q == S_SH_WR) || (state_q == S_WRITE);
		mem_raddr  = (state_q == S_READ) ? AW'(pos_q) : AW'(src);
		mem_waddr  = (state_q == S_SH_WR) ? AW'(idx_q) : AW'(pos_q);
		mem_wdata  = (state_q == S_SH_WR) ? mem_rdata : word_q;
	end

	// Sequence one operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			op_q     <= OP_INSERT;
			status_q <= ST_DONE;
		end else if (cfg_we) begin
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_op;
						pos_q    <= pos_in;
						word_q   <= in_word;
						status_q <= ST_DONE;
						idx_q    <= count_q;
						stop_q   <= pos_in;
						case (in_op)
							OP_INSERT: begin
								if (pos_in > count_q) begin
									status_q <= ST_INVALID;
									state_q  <= S_FIN;
								end else if (count_q >= cap_eff) begin
									status_q <= ST_OVERFLOW;
									state_q  <= S_FIN;
								end else if (pos_in == count_q) begin
									state_q <= S_WRITE;
								end else begin
									state_q <= S_SH_RD;
								end
							end
							OP_APPEND: begin
								pos_q <= count_q;
								if (count_q >= cap_eff) begin
									status_q <= ST_OVERFLOW;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_WRITE;
								end
							end
							OP_DELETE: begin
								idx_q  <= pos_in;
								stop_q <= count_q - CNT_W'(1);
								if (pos_in >= count_q) begin
									status_q <= ST_INVALID;
									state_q  <= S_FIN;
								end else if (pos_in == count_q - CNT_W'(1)) begin
									count_q <= count_q - CNT_W'(1);
									state_q <= S_FIN;
								end else begin
									state_q <= S_SH_RD;
								end
							end
							OP_EDIT: begin
								if (pos_in >= count_q) begin
									status_q <= ST_INVALID;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_WRITE;
								end
							end
							OP_READ: begin
								if (pos_in >= count_q) begin
									status_q <= ST_INVALID;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								status_q <= ST_INVALID;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					idx_q <= src;
					if (src != stop_q) begin
						state_q <= S_SH_RD;
					end else if (op_q == OP_INSERT) begin
						state_q <= S_WRITE;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_FIN;
					end
				end
				S_WRITE: begin
					if (op_q == OP_INSERT || op_q == OP_APPEND) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_FIN;
				end
				S_READ: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the finished result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (op_q == OP_READ && status_q == ST_DONE) begin
				read_value_q <= rd_ext;
			end else if (op_q == OP_READ) begin
				read_value_q <= '1;
			end else begin
				read_value_q <= '0;
			end
			status_out_q <= status_q;
			fill_q       <= count_q;
			full_q       <= (count_q == cap_eff);
			empty_q      <= (count_q == '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign out_read_value = read_value_q;
	assign out_status     = status_out_q;
	assign out_fill_count = fill_q;
	assign out_is_full    = full_q;
	assign out_is_empty   = empty_q;

endmodule

// ----- design/shifting_list_store_core.sv -----
// Ordered list store: insert and delete shift entries one at a time through one memory,
// each move a read state then a write state (S_SH_RD, S_SH_WR). One operation at a time:
// input ready only while the sequencer is idle, so a new operation is taken only after the
// last result is loaded into the output register. Reset: arst_n clears the fill count and
// sets capacity to 16.
module shifting_list_store_core import sls_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	sls_in_if.sink           in_ch,
	sls_out_if.source        out_ch
);

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

	logic [CNT_W-1:0]     cap_q;
	logic [CNT_W-1:0]     cap_eff;
	logic [WORD_BITS-1:0] word_in;
	logic [VAL_W-1:0]     rd_ext;
	logic [VAL_W-1:0]     read_value;
	mem_cmd_t             mem_cmd;
	logic [AW-1:0]        mem_waddr;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [WORD_BITS-1:0] mem_rdata;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Saturate capacity at the storage depth, and at 31 at most
	assign cap_eff = (cap_q > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : cap_q;

	// Fit the input word to the stored width and sign-extend stored words on read
	for (genvar b = 0; b < WORD_BITS; b++) begin : g_word
		if (b < VAL_W) begin : g_bit
			assign word_in[b] = in_ch.value_in[b];
		end else begin : g_pad
			assign word_in[b] = 1'b0;
		end
	end

	for (genvar b = 0; b < VAL_W; b++) begin : g_rd
		if (b < WORD_BITS) begin : g_bit
			assign rd_ext[b] = mem_rdata[b];
		end else begin : g_sign
			assign rd_ext[b] = mem_rdata[WORD_BITS-1];
		end
	end

	sls_ctrl #(
		.WORD_BITS (WORD_BITS),
		.AW        (AW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cap_eff        (cap_eff),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.in_op          (in_ch.operation),
		.in_pos         (in_ch.position),
		.in_word        (word_in),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_read_value (read_value),
		.out_status     (out_ch.status),
		.out_fill_count (out_ch.fill_count),
		.out_is_full    (out_ch.is_full),
		.out_is_empty   (out_ch.is_empty),
		.mem_cmd        (mem_cmd),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata),
		.rd_ext         (rd_ext)
	);

	assign out_ch.read_value = read_value;

	sls_mem #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS),
		.AW        (AW)
	) u_mem (
		.clk   (clk),
		.cmd   (mem_cmd),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
